// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the lru key-value cache
// no dependencies

package lkvc_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int DATA_W       = 32;

    // request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // one cache entry as it moves along the cell chain
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;    // capture key compare
        logic shift_en;  // take the neighbor's entry
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } state_t;

endpackage

// ----- sv/lkvc_cell.sv -----
`timescale 1ns / 1ps
// one cell of the recency-ordered chain: holds one entry and its match flag
// depends on lkvc_pkg

module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [DATA_W-1:0] cmp_key,
    input  entry_t            ent_in,
    output entry_t            ent_out,
    output logic              match
);

    logic              valid_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              match_reg;
    logic              match_next;

    assign match_next = valid_reg && (key_reg == cmp_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.shift_en)
            begin
                valid_reg <= ent_in.valid;
            end
            if (ctl.cmp_en)
            begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            key_reg   <= ent_in.key;
            value_reg <= ent_in.value;
        end
    end

    assign ent_out.valid = valid_reg;
    assign ent_out.key   = key_reg;
    assign ent_out.value = value_reg;
    assign match         = match_reg;

endmodule

// ----- sv/lru_key_value_cache_core.sv -----
`timescale 1ns / 1ps
// lru key-value cache: request sequencer around a chain of recency-ordered cells
// depends on lkvc_pkg and lkvc_cell
// a taken request moves the sequencer to ST_UPD; done_reg and the result registers
//   are loaded from that update state, and the word is taken while done is high
// requests do not overlap: start is not taken while busy, and each request is a
//   key compare in every cell followed by a shift along the chain
// reset clears every valid bit, so the cache comes up empty with no clearing pass
// results cannot be stalled: each word is on the ports for one cycle with done

module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key
);

    // cell 0 holds the most recent entry, cell CAPACITY-1 the least recent;
    // valid entries always fill cells 0 .. count-1 in order

    state_t            state_reg, state_next;
    logic              done_reg;
    logic              accept;

    // request word captured at accept
    logic              req_put_reg;
    logic [DATA_W-1:0] req_key_reg;
    logic [DATA_W-1:0] req_value_reg;

    // result word
    logic              hit_reg,  hit_next;
    logic [DATA_W-1:0] rdval_reg, rdval_next;
    logic              evict_reg, evict_next;
    logic [DATA_W-1:0] evkey_reg, evkey_next;

    entry_t            ent    [CAPACITY];
    entry_t            chain_in [CAPACITY];
    cell_ctl_t         ctl    [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic              any_hit;
    logic              put_miss;
    logic              in_upd;
    logic [DATA_W-1:0] sel_value;
    entry_t            head;

    assign accept = start && (state_reg == ST_IDLE);
    assign in_upd = (state_reg == ST_UPD);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= in_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_put_reg   <= (req_type == REQ_PUT);
            req_key_reg   <= key;
            req_value_reg <= value;
        end
    end

    // hit detection and value select over the one-hot match vector
    assign any_hit  = |match_vec;
    assign put_miss = req_put_reg && !any_hit;

    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_value = sel_value | (ent[i].value & {DATA_W{match_vec[i]}});
        end
    end

    // new head of the chain: the requested key, with the put value or the hit value
    assign head.valid = 1'b1;
    assign head.key   = req_key_reg;
    assign head.value = req_put_reg ? req_value_reg : sel_value;

    // a cell shifts when the hit lies at or below it, or on any put miss
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign chain_in[i] = head;
        end
        else
        begin : g_body
            assign chain_in[i] = ent[i-1];
        end

        assign ctl[i].cmp_en   = accept;
        assign ctl[i].shift_en = in_upd && (put_miss || ((match_vec >> i) != '0));

        lkvc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[i]),
            .cmp_key (key),
            .ent_in  (chain_in[i]),
            .ent_out (ent[i]),
            .match   (match_vec[i])
        );
    end

    // result word; the last cell is valid only when the cache is full
    always_comb
    begin
        hit_next   = any_hit;
        rdval_next = (!req_put_reg && any_hit) ? sel_value : '0;
        evict_next = put_miss && ent[CAPACITY-1].valid;
        evkey_next = evict_next ? ent[CAPACITY-1].key : '0;
    end

    always_ff @(posedge clk)
    begin
        if (in_upd)
        begin
            hit_reg   <= hit_next;
            rdval_reg <= rdval_next;
            evict_reg <= evict_next;
            evkey_reg <= evkey_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rdval_reg;
    assign evicted     = evict_reg;
    assign evicted_key = evkey_reg;

endmodule

// ----- sv/lkvc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the lru key-value cache, bound to the top level
// depends on lkvc_pkg and lru_key_value_cache_core

module lkvc_checker
    import lkvc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              hit,
    input logic [DATA_W-1:0] read_value,
    input logic              evicted,
    input logic [DATA_W-1:0] evicted_key
);

    // a taken request makes the block busy for one cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    // the word follows the busy cycle
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("no result word after busy cycle");

    // a result only appears for a request that was taken
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a request");

    // eviction only on a miss, and an evicting miss returns no value
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (!hit && (read_value == '0)))
        else $error("eviction reported on a hit");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_key == '0))
        else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);

// ----- tb/lru_key_value_cache_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for lru_key_value_cache_core: directed and random get/put words
// checked against an lru cache predictor held in a small scoreboard class
// depends on lkvc_pkg and the cache core rtl

module lru_key_value_cache_core_tb
    import lkvc_pkg::*;
();

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int PHASE_ITEMS    = 200;
    localparam int POOL_MAX       = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // one result word as it leaves the core
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } cache_word_t;

    // lru predictor plus the queue of result words still owed by the core
    class cache_scoreboard;
        logic [DATA_W-1:0] slot_key   [CAPACITY_DEF];
        logic [DATA_W-1:0] slot_value [CAPACITY_DEF];
        logic              slot_valid [CAPACITY_DEF];
        int                slot_rank  [CAPACITY_DEF];
        cache_word_t       expected_words[$];
        int errors;
        int n_gets;
        int n_puts;
        int n_hits;
        int n_evictions;
        int n_checked;

        function new();
            for (int i = 0; i < CAPACITY_DEF; i++)
            begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            errors      = 0;
            n_gets      = 0;
            n_puts      = 0;
            n_hits      = 0;
            n_evictions = 0;
            n_checked   = 0;
        endfunction

        // work out the result of one accepted request and update the cache image
        function void note_request(logic req, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
            int found;
            int free_slot;
            int oldest;
            int oldest_rank;
            int slot;
            int r;
            cache_word_t word;
            found       = -1;
            free_slot   = -1;
            oldest      = -1;
            oldest_rank = 0;
            word        = '0;
            if (req == REQ_PUT)
                n_puts++;
            else
                n_gets++;
            for (int i = 0; i < CAPACITY_DEF; i++)
            begin
                if (slot_valid[i])
                begin
                    if (found < 0 && slot_key[i] == k)
                        found = i;
                    if (oldest < 0 || slot_rank[i] >= oldest_rank)
                    begin
                        oldest      = i;
                        oldest_rank = slot_rank[i];
                    end
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (found >= 0)
            begin
                word.hit = 1'b1;
                n_hits++;
                if (req == REQ_PUT)
                    slot_value[found] = v;
                else
                    word.read_value = slot_value[found];
                // entries more recent than the hit age by one
                r = slot_rank[found];
                for (int i = 0; i < CAPACITY_DEF; i++)
                    if (slot_valid[i] && slot_rank[i] < r)
                        slot_rank[i]++;
                slot_rank[found] = 0;
            end
            else if (req == REQ_PUT)
            begin
                if (free_slot >= 0)
                    slot = free_slot;
                else
                begin
                    slot             = oldest;
                    word.evicted     = 1'b1;
                    word.evicted_key = slot_key[slot];
                    n_evictions++;
                end
                for (int i = 0; i < CAPACITY_DEF; i++)
                    if (slot_valid[i] && i != slot)
                        slot_rank[i]++;
                slot_key[slot]   = k;
                slot_value[slot] = v;
                slot_valid[slot] = 1'b1;
                slot_rank[slot]  = 0;
            end
            // owed words queue up oldest first
            expected_words = {expected_words, word};
        endfunction

        // compare one result word with the oldest one owed
        function void check_word(cache_word_t got);
            cache_word_t exp_word;
            if (expected_words.size() == 0)
            begin
                $error("result word with no request pending");
                errors++;
                return;
            end
            exp_word = expected_words.pop_front();
            n_checked++;
            if (got.hit !== exp_word.hit)
            begin
                $error("hit: expected %0d, got %0d", exp_word.hit, got.hit);
                errors++;
            end
            if (got.read_value !== exp_word.read_value)
            begin
                $error("read_value: expected %h, got %h", exp_word.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== exp_word.evicted)
            begin
                $error("evicted: expected %0d, got %0d", exp_word.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== exp_word.evicted_key)
            begin
                $error("evicted_key: expected %h, got %h", exp_word.evicted_key,
                       got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;

    cache_scoreboard sb;
    int              idle_cycles;
    bit              no_idle;

    lru_key_value_cache_core #(
        .CAPACITY (CAPACITY_DEF)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // gap before the next word: none half the time, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    // present one request word at the falling edge, hold it until the core takes it
    task automatic send_word(input logic req, input logic [DATA_W-1:0] k,
                             input logic [DATA_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start    <= 1'b1;
        req_type <= req;
        key      <= k;
        value    <= v;
        // taken at the first rising edge with busy low
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req, k, v);
    endtask

    // results cannot be held off: take every word the strobe marks
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word('{hit, read_value, evicted, evicted_key});
    end

    // watchdog: too long with nothing accepted on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("lru_key_value_cache_core_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [DATA_W-1:0] key_pool [POOL_MAX];
        int                pool_size;
        int                sent;
        int                pick;
        logic              req;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;

        sb          = new();
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_GET;
        key         = '0;
        value       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty miss, key and value extremes, update, fill, evictions
        send_word(REQ_GET, 32'h0000_0000, 32'hDEAD_BEEF, pick_gap());
        send_word(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF, pick_gap());
        send_word(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000, pick_gap());
        send_word(REQ_PUT, 32'h0000_0000, 32'h0000_0000, pick_gap());
        send_word(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pick_gap());
        send_word(REQ_GET, 32'h8000_0000, 32'h0000_0000, pick_gap());
        send_word(REQ_PUT, 32'h0000_0000, 32'h1234_5678, pick_gap());
        send_word(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF, pick_gap());
        for (int i = 1; i <= 4; i++)
            send_word(REQ_PUT, i, $urandom, pick_gap());
        // cache now full: new keys push out the least recent entry
        send_word(REQ_PUT, 32'd5, 32'hA5A5_A5A5, pick_gap());
        send_word(REQ_PUT, 32'd6, 32'h5A5A_5A5A, pick_gap());
        send_word(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, pick_gap());
        // hit in the middle of the recency order, then update on a full cache
        send_word(REQ_GET, 32'd1, 32'h0000_0000, pick_gap());
        send_word(REQ_PUT, 32'd1, 32'h8000_0000, pick_gap());
        send_word(REQ_GET, 32'd1, 32'h0000_0000, pick_gap());
        send_word(REQ_GET, 32'h8000_0000, 32'h0000_0000, pick_gap());
        send_word(REQ_PUT, 32'd7, 32'h0F0F_0F0F, pick_gap());
        send_word(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, pick_gap());
        send_word(REQ_GET, 32'd5, 32'h0000_0000, pick_gap());

        // random: phases with their own key pool, sized below and above capacity
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pool_size = $urandom_range(3, POOL_MAX);
            no_idle   = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < POOL_MAX; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       key_pool[i] = 32'h0000_0000;
                    1:       key_pool[i] = 32'hFFFF_FFFF;
                    2:       key_pool[i] = 32'h8000_0000;
                    3:       key_pool[i] = 32'h7FFF_FFFF;
                    default: key_pool[i] = $urandom;
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS && sent < RANDOM_ITEMS; n++)
            begin
                req  = $urandom_range(0, 1) ? REQ_PUT : REQ_GET;
                pick = $urandom_range(0, 99);
                // mostly pool keys so hits and evictions are frequent
                if (pick < 85)
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    k = $urandom;
                case ($urandom_range(0, 9))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                send_word(req, k, v, pick_gap());
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // drain: wait for every owed word, then a few quiet cycles
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d gets and %0d puts, %0d result words checked",
                 sb.n_gets, sb.n_puts, sb.n_checked);
        $display("saw %0d hits and %0d evictions", sb.n_hits, sb.n_evictions);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("lru_key_value_cache_core_tb OK");
        else
            $display("lru_key_value_cache_core_tb NOT OK");
        $finish;
    end

endmodule
